// File: sv/s5hp_pkg.sv
`default_nettype none

package s5hp_pkg;

  // length of the hex hash carried in the domain field
  localparam int unsigned HASH_LEN = 40;

  // address width of the hash memory
  localparam int unsigned HASH_AW = (HASH_LEN > 1) ? $clog2(HASH_LEN) : 1;

  // result index width: wide enough for a hash run plus its verdict and a failure reply
  localparam int unsigned IDX_W = ($clog2(HASH_LEN + 1) > 4) ? $clog2(HASH_LEN + 1) : 4;

  // result runs that the parser hands to the sender
  typedef enum logic [2:0] {
    JOB_REJECT,
    JOB_GREET_OK,
    JOB_GREET_NO,
    JOB_FAIL,
    JOB_ACCEPT
  } job_e;

  typedef struct packed {
    logic       valid;
    job_e       kind;
    logic [7:0] code;
  } job_t;

  // hash memory write port
  typedef struct packed {
    logic               en;
    logic [HASH_AW-1:0] addr;
    logic [7:0]         data;
  } wr_t;

endpackage

`default_nettype wire

// File: sv/s5hp_parser.sv
`default_nettype none

module s5hp_parser import s5hp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire logic       kind_i,
  input  wire logic [7:0] data_byte_i,
  output job_t            job_o,
  output wr_t             wr_o
);

  localparam logic [2:0] PH_GREET_HDR     = 3'd0;
  localparam logic [2:0] PH_GREET_METHODS = 3'd1;
  localparam logic [2:0] PH_REQUEST       = 3'd2;
  localparam logic [2:0] PH_ACCEPTED      = 3'd3;
  localparam logic [2:0] PH_CLOSED        = 3'd4;

  localparam logic [7:0] SOCKS_VER   = 8'h05;
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] M_NOAUTH    = 8'h00;
  localparam logic [7:0] REP_CMD     = 8'h07;
  localparam logic [7:0] REP_ATYP    = 8'h08;
  localparam logic [7:0] REP_HOST    = 8'h04;

  logic [2:0] phase_q, phase_d;
  logic [8:0] bc_q, bc_d;
  logic [7:0] ll_q, ll_d;
  logic       noauth_q, noauth_d;
  logic       hdr_ok_q, hdr_ok_d;
  logic       hex_ok_q, hex_ok_d;

  logic [8:0] bc_inc;
  logic [8:0] pos;
  logic       noauth_n;

  function automatic logic is_hex(logic [7:0] c);
    return (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c inside {["A":"F"]}) ? c + 8'h20 : c;
  endfunction

  assign bc_inc   = bc_q + 9'd1;
  assign pos      = bc_q - 9'd5;
  assign noauth_n = noauth_q | (data_byte_i == M_NOAUTH);

  // per-beat parse of the greeting and request
  always_comb begin
    phase_d  = phase_q;
    bc_d     = bc_q;
    ll_d     = ll_q;
    noauth_d = noauth_q;
    hdr_ok_d = hdr_ok_q;
    hex_ok_d = hex_ok_q;
    job_o.valid = 1'b0;
    job_o.kind  = JOB_REJECT;
    job_o.code  = 8'h00;
    wr_o.en     = 1'b0;
    wr_o.addr   = pos[HASH_AW-1:0];
    wr_o.data   = to_lower(data_byte_i);

    if (acc_i && kind_i) begin
      // new session
      phase_d  = PH_GREET_HDR;
      bc_d     = '0;
      ll_d     = '0;
      noauth_d = 1'b0;
      hdr_ok_d = 1'b0;
      hex_ok_d = 1'b1;
    end else if (acc_i) begin
      case (phase_q)
        PH_GREET_HDR: begin
          if (bc_q == 9'd0) begin
            hdr_ok_d = (data_byte_i == SOCKS_VER);
            bc_d     = 9'd1;
          end else if (!hdr_ok_q) begin
            phase_d     = PH_CLOSED;
            job_o.valid = 1'b1;
            job_o.kind  = JOB_REJECT;
          end else begin
            ll_d     = data_byte_i;
            noauth_d = 1'b0;
            bc_d     = '0;
            if (data_byte_i == 8'h00) begin
              phase_d     = PH_CLOSED;
              job_o.valid = 1'b1;
              job_o.kind  = JOB_GREET_NO;
            end else begin
              phase_d = PH_GREET_METHODS;
            end
          end
        end

        PH_GREET_METHODS: begin
          noauth_d = noauth_n;
          bc_d     = bc_inc;
          if (bc_inc >= {1'b0, ll_q}) begin
            job_o.valid = 1'b1;
            if (noauth_n) begin
              job_o.kind = JOB_GREET_OK;
              phase_d    = PH_REQUEST;
              bc_d       = '0;
              hdr_ok_d   = 1'b0;
              ll_d       = '0;
            end else begin
              job_o.kind = JOB_GREET_NO;
              phase_d    = PH_CLOSED;
            end
          end
        end

        PH_REQUEST: begin
          bc_d = bc_inc;
          if (bc_q == 9'd0) begin
            hdr_ok_d = (data_byte_i == SOCKS_VER);
          end else if (bc_q == 9'd1) begin
            if (data_byte_i != CMD_CONNECT) hdr_ok_d = 1'b0;
          end else if (bc_q == 9'd3) begin
            ll_d = data_byte_i;
          end else if (bc_q == 9'd4) begin
            if (!hdr_ok_q) begin
              bc_d        = bc_q;
              phase_d     = PH_CLOSED;
              job_o.valid = 1'b1;
              job_o.kind  = JOB_FAIL;
              job_o.code  = REP_CMD;
            end else if (ll_q != ATYP_DOMAIN) begin
              bc_d        = bc_q;
              phase_d     = PH_CLOSED;
              job_o.valid = 1'b1;
              job_o.kind  = JOB_FAIL;
              job_o.code  = REP_ATYP;
            end else begin
              ll_d     = data_byte_i;
              hex_ok_d = 1'b1;
            end
          end else if (bc_q >= 9'd5) begin
            // store one hash character
            if (pos < {1'b0, ll_q} && ll_q == 8'(HASH_LEN) && pos < 9'(HASH_LEN)) begin
              if (!is_hex(data_byte_i)) hex_ok_d = 1'b0;
              wr_o.en = 1'b1;
            end
            // second port byte closes the request
            if (pos == {1'b0, ll_q} + 9'd1) begin
              bc_d        = bc_q;
              job_o.valid = 1'b1;
              if (ll_q != 8'(HASH_LEN) || !hex_ok_q) begin
                phase_d    = PH_CLOSED;
                job_o.kind = JOB_FAIL;
                job_o.code = REP_HOST;
              end else begin
                phase_d    = PH_ACCEPTED;
                job_o.kind = JOB_ACCEPT;
              end
            end
          end
        end

        default: begin
          // accepted or closed: beats are dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_GREET_HDR;
      bc_q     <= '0;
      ll_q     <= '0;
      noauth_q <= 1'b0;
      hdr_ok_q <= 1'b0;
      hex_ok_q <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      bc_q     <= bc_d;
      ll_q     <= ll_d;
      noauth_q <= noauth_d;
      hdr_ok_q <= hdr_ok_d;
      hex_ok_q <= hex_ok_d;
    end
  end

  // hash writes happen only while parsing the request
  a_wr_in_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> phase_q == PH_REQUEST)
    else $error("hash write outside request phase");

  // a result run always leaves the session in request, accepted or closed
  a_job_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_o.valid |=> (phase_q == PH_REQUEST || phase_q == PH_ACCEPTED ||
                     phase_q == PH_CLOSED))
    else $error("result run left session in a parsing phase");

  // the greeting header holds at most the version byte
  a_hdr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_GREET_HDR |-> bc_q <= 9'd1)
    else $error("greeting header count out of range");

endmodule

`default_nettype wire

// File: sv/s5hp_emit.sv
`default_nettype none

module s5hp_emit import s5hp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  job_t            job_i,
  input  wr_t             wr_i,
  output logic            busy_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      out_kind_o,
  output logic [7:0]      out_byte_o,
  output logic            verdict_o,
  output logic            last_o
);

  localparam logic [1:0] OK_REPLY   = 2'd0;
  localparam logic [1:0] OK_HASH    = 2'd1;
  localparam logic [1:0] OK_VERDICT = 2'd2;

  localparam logic [7:0] SOCKS_VER  = 8'h05;
  localparam logic [7:0] M_NONE     = 8'hff;
  localparam logic [7:0] ATYP_IPV4  = 8'h01;

  typedef struct packed {
    logic [1:0] okind;
    logic [7:0] obyte;
    logic       verdict;
    logic       last;
    logic       from_mem;
  } item_t;

  // one result of a run, by position
  function automatic item_t item_at(job_e kind, logic [7:0] code, logic [IDX_W-1:0] idx);
    item_t it;
    it = '0;
    it.okind = OK_REPLY;
    case (kind)
      JOB_GREET_OK: begin
        it.obyte = (idx == '0) ? SOCKS_VER : 8'h00;
        it.last  = (idx == IDX_W'(1));
      end
      JOB_GREET_NO: begin
        if (idx == '0) begin
          it.obyte = SOCKS_VER;
        end else if (idx == IDX_W'(1)) begin
          it.obyte = M_NONE;
        end else begin
          it.okind   = OK_VERDICT;
          it.verdict = 1'b1;
          it.last    = 1'b1;
        end
      end
      JOB_FAIL: begin
        if (idx == '0) begin
          it.obyte = SOCKS_VER;
        end else if (idx == IDX_W'(1)) begin
          it.obyte = code;
        end else if (idx == IDX_W'(3)) begin
          it.obyte = ATYP_IPV4;
        end else if (idx == IDX_W'(10)) begin
          it.okind   = OK_VERDICT;
          it.verdict = 1'b1;
          it.last    = 1'b1;
        end
      end
      JOB_ACCEPT: begin
        if (idx == IDX_W'(HASH_LEN)) begin
          it.okind = OK_VERDICT;
          it.last  = 1'b1;
        end else begin
          it.okind    = OK_HASH;
          it.from_mem = 1'b1;
        end
      end
      default: begin
        it.okind   = OK_VERDICT;
        it.verdict = 1'b1;
        it.last    = 1'b1;
      end
    endcase
    return it;
  endfunction

  logic [7:0]       mem_q [HASH_LEN];
  logic [7:0]       rd_data_q;

  logic             job_active_q;
  job_e             job_kind_q;
  logic [7:0]       job_code_q;
  logic [IDX_W-1:0] idx_q;

  logic             out_valid_q;
  logic [1:0]       out_kind_q;
  logic [7:0]       out_byte_q;
  logic             verdict_q;
  logic             last_q;
  logic             from_mem_q;

  item_t            cur;
  logic             adv;

  assign cur    = item_at(job_kind_q, job_code_q, idx_q);
  assign adv    = job_active_q && (!out_valid_q || !out_stall_i);
  assign busy_o = job_active_q;

  // hash memory write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[wr_i.addr] <= wr_i.data;
  end

  // hash memory read port, registered read
  always_ff @(posedge clk_i) begin
    if (adv && cur.from_mem) rd_data_q <= mem_q[idx_q[HASH_AW-1:0]];
  end

  // run sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_active_q <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (job_i.valid) begin
        job_active_q <= 1'b1;
        idx_q        <= '0;
      end else if (adv) begin
        idx_q <= idx_q + IDX_W'(1);
        if (cur.last) job_active_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // run descriptor and output payload
  always_ff @(posedge clk_i) begin
    if (job_i.valid) begin
      job_kind_q <= job_i.kind;
      job_code_q <= job_i.code;
    end
    if (adv) begin
      out_kind_q <= cur.okind;
      out_byte_q <= cur.obyte;
      verdict_q  <= cur.verdict;
      last_q     <= cur.last;
      from_mem_q <= cur.from_mem;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = from_mem_q ? rd_data_q : out_byte_q;
  assign verdict_o   = verdict_q;
  assign last_o      = last_q;

  // a new run never lands on one still being sent
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_i.valid |-> !job_active_q)
    else $error("run loaded while sender busy");

  // the last result of a run frees the sender
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && cur.last) |=> !job_active_q)
    else $error("sender still busy after last result");

  // a verdict always closes its run
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == OK_VERDICT) |-> last_q)
    else $error("verdict not marked last");

endmodule

`default_nettype wire

// File: sv/socks5_connect_handshake_parser_top.sv
// Server side of a SOCKS5 greeting and CONNECT request for one session.
// Input channel: in_valid_i / in_stall_o, one beat per client byte (kind_i = 0)
// or a new-session marker (kind_i = 1, data_byte_i ignored).
// Output channel: out_valid_o / out_stall_i, one beat per result: reply byte,
// lower-case hash character or session verdict; last_o marks the end of the
// results caused by one input beat.
// Throughput: a beat that causes no result is taken every cycle. A beat that
// causes N results (2, 3, 1, 11 or HASH_LEN + 1) holds in_stall_o high until
// its run is sent; while out_stall_i is low the sender moves one result per
// cycle through the single read port of the hash memory. The first result
// shows once the run is loaded into the sender and then the output register.
// When out_stall_i is high the output register holds its beat and the run
// pauses; input beats wait behind it.
// Reset puts the session in the greeting phase with the output empty. The
// hash memory needs no clearing: a run reads only entries written earlier in
// the same request.
`default_nettype none

module socks5_connect_handshake_parser_top import s5hp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       kind_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      out_kind_o,
  output logic [7:0]      out_byte_o,
  output logic            verdict_o,
  output logic            last_o
);

  job_t job;
  wr_t  wr;
  logic busy;
  logic acc;

  // input beats wait while a result run is in flight
  assign in_stall_o = busy;
  assign acc        = in_valid_i && !busy;

  s5hp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .job_o       (job),
    .wr_o        (wr)
  );

  s5hp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .wr_i        (wr),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .verdict_o   (verdict_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// File: bench/tb_socks5_connect_handshake_parser_top.sv
`default_nettype none

module tb_socks5_connect_handshake_parser_top;
  import s5hp_pkg::*;

  // beat kinds on the input side
  localparam logic BEAT_BYTE = 1'b0;
  localparam logic BEAT_NEW  = 1'b1;

  // result kinds on the output side
  localparam logic [1:0] OUT_REPLY   = 2'd0;
  localparam logic [1:0] OUT_HASH    = 2'd1;
  localparam logic [1:0] OUT_VERDICT = 2'd2;

  localparam logic VERDICT_ACCEPT = 1'b0;
  localparam logic VERDICT_REJECT = 1'b1;

  // protocol bytes
  localparam logic [7:0] SOCKS_VER        = 8'h05;
  localparam logic [7:0] METHOD_NOAUTH    = 8'h00;
  localparam logic [7:0] METHOD_NONE      = 8'hFF;
  localparam logic [7:0] CMD_CONNECT      = 8'h01;
  localparam logic [7:0] ATYP_IPV4        = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN      = 8'h03;
  localparam logic [7:0] REP_HOST_UNREACH = 8'h04;
  localparam logic [7:0] REP_CMD_UNSUP    = 8'h07;
  localparam logic [7:0] REP_ATYP_UNSUP   = 8'h08;

  localparam int TOTAL_BEATS    = 230;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_LIMIT     = 4000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int REPORT_MAX     = 10;

  typedef enum logic [2:0] {
    SES_GREET_HDR,
    SES_METHODS,
    SES_REQUEST,
    SES_ACCEPTED,
    SES_CLOSED
  } ses_phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       verdict;
    logic       last;
  } result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       kind_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] out_kind_o;
  logic [7:0] out_byte_o;
  logic       verdict_o;
  logic       last_o;

  // session state mirrored from the client byte stream
  ses_phase_e phase;
  logic [8:0] byte_cnt;
  logic [7:0] list_len;
  logic       noauth_seen;
  logic       hdr_ok;
  logic       hex_ok;
  logic [7:0] hash_mem [HASH_LEN];

  result_t session_out_q[$];
  result_t got_beat;
  result_t want_beat;

  bit idle_on;
  bit hold_pending;
  int hold_left;
  int stall_left;
  int mismatches;
  int beats_sent;
  int beats_counted;
  int sessions_started;
  int sessions_accepted;
  int sessions_rejected;
  int results_checked;

  socks5_connect_handshake_parser_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .verdict_o   (verdict_o),
    .last_o      (last_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // gap length for either side: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_result(logic [1:0] k, logic [7:0] d, logic v);
    result_t item;
    item.kind    = k;
    item.data    = d;
    item.verdict = v;
    item.last    = 1'b0;
    session_out_q.push_back(item);
  endfunction

  function automatic void push_reject();
    phase = SES_CLOSED;
    sessions_rejected++;
    push_result(OUT_VERDICT, 8'h00, VERDICT_REJECT);
  endfunction

  // ten-byte failure reply, then close
  function automatic void push_fail(logic [7:0] code);
    push_result(OUT_REPLY, SOCKS_VER, 1'b0);
    push_result(OUT_REPLY, code, 1'b0);
    push_result(OUT_REPLY, 8'h00, 1'b0);
    push_result(OUT_REPLY, ATYP_IPV4, 1'b0);
    for (int i = 0; i < 6; i++) push_result(OUT_REPLY, 8'h00, 1'b0);
    push_reject();
  endfunction

  function automatic void clear_session();
    phase       = SES_GREET_HDR;
    byte_cnt    = '0;
    list_len    = '0;
    noauth_seen = 1'b0;
    hdr_ok      = 1'b0;
    hex_ok      = 1'b1;
  endfunction

  // advance the session by one beat, queue the results it causes;
  // returns 0 when the beat is ignored
  function automatic bit parse_client_beat(logic kd, logic [7:0] b);
    int         n0;
    int         pos;
    bit         advance;
    logic [7:0] c;
    n0      = session_out_q.size();
    advance = 1'b1;
    if (kd == BEAT_NEW) begin
      clear_session();
      sessions_started++;
      return 1'b1;
    end
    case (phase)
      SES_GREET_HDR: begin
        if (byte_cnt == 0) begin
          hdr_ok   = (b == SOCKS_VER);
          byte_cnt = 9'd1;
        end else if (!hdr_ok) begin
          push_reject();
        end else begin
          list_len    = b;
          noauth_seen = 1'b0;
          byte_cnt    = '0;
          if (list_len == 0) begin
            push_result(OUT_REPLY, SOCKS_VER, 1'b0);
            push_result(OUT_REPLY, METHOD_NONE, 1'b0);
            push_reject();
          end else begin
            phase = SES_METHODS;
          end
        end
      end
      SES_METHODS: begin
        if (b == METHOD_NOAUTH) noauth_seen = 1'b1;
        byte_cnt = byte_cnt + 9'd1;
        if (byte_cnt >= list_len) begin
          push_result(OUT_REPLY, SOCKS_VER, 1'b0);
          if (noauth_seen) begin
            push_result(OUT_REPLY, METHOD_NOAUTH, 1'b0);
            phase    = SES_REQUEST;
            byte_cnt = '0;
            hdr_ok   = 1'b0;
            list_len = '0;
          end else begin
            push_result(OUT_REPLY, METHOD_NONE, 1'b0);
            push_reject();
          end
        end
      end
      SES_REQUEST: begin
        if (byte_cnt == 0) begin
          hdr_ok = (b == SOCKS_VER);
        end else if (byte_cnt == 1) begin
          if (b != CMD_CONNECT) hdr_ok = 1'b0;
        end else if (byte_cnt == 3) begin
          list_len = b;
        end else if (byte_cnt == 4) begin
          if (!hdr_ok) begin
            push_fail(REP_CMD_UNSUP);
            advance = 1'b0;
          end else if (list_len != ATYP_DOMAIN) begin
            push_fail(REP_ATYP_UNSUP);
            advance = 1'b0;
          end else begin
            list_len = b;
            hex_ok   = 1'b1;
          end
        end else if (byte_cnt >= 5) begin
          pos = int'(byte_cnt) - 5;
          // domain bytes are kept only when the length matches the hash
          if (pos < int'(list_len) && int'(list_len) == HASH_LEN && pos < HASH_LEN) begin
            c = b;
            if (!((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                  (c >= "A" && c <= "F"))) hex_ok = 1'b0;
            if (c >= "A" && c <= "F") c = c + ("a" - "A");
            hash_mem[pos] = c;
          end
          // second port byte closes the request
          if (pos == int'(list_len) + 1) begin
            advance = 1'b0;
            if (int'(list_len) != HASH_LEN || !hex_ok) begin
              push_fail(REP_HOST_UNREACH);
            end else begin
              for (int i = 0; i < HASH_LEN; i++) push_result(OUT_HASH, hash_mem[i], 1'b0);
              phase = SES_ACCEPTED;
              sessions_accepted++;
              push_result(OUT_VERDICT, 8'h00, VERDICT_ACCEPT);
            end
          end
        end
        if (advance) byte_cnt = byte_cnt + 9'd1;
      end
      default: return 1'b0;
    endcase
    if (session_out_q.size() > n0) session_out_q[session_out_q.size() - 1].last = 1'b1;
    return 1'b1;
  endfunction

  // offer one beat after a random gap and wait for it to be taken
  task automatic send_beat(logic kd, logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kd;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (parse_client_beat(kd, b)) beats_counted++;
  endtask

  // one hex digit in either case
  function automatic logic [7:0] rand_hex_char();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) return 8'("0" + d);
    if ($urandom_range(0, 1) == 0) return 8'("a" + d - 10);
    return 8'("A" + d - 10);
  endfunction

  // a full session: greeting then CONNECT; broken sessions bend some fields
  task automatic send_session(bit well_formed);
    logic [7:0] bytes_q[$];
    int         nmeth;
    int         alen;
    int         noauth_at;
    int         cut;
    bit         bad;
    bytes_q.delete();
    bad = !well_formed;
    // greeting
    bytes_q.push_back((bad && $urandom_range(0, 9) == 0) ? 8'($urandom) : SOCKS_VER);
    if (bad && $urandom_range(0, 9) == 0) nmeth = 0;
    else if ($urandom_range(0, 9) == 0) nmeth = $urandom_range(5, 20);
    else nmeth = $urandom_range(1, 4);
    bytes_q.push_back(8'(nmeth));
    noauth_at = (bad && $urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, nmeth - 1);
    for (int i = 0; i < nmeth; i++) begin
      if (i == noauth_at) bytes_q.push_back(METHOD_NOAUTH);
      else bytes_q.push_back(8'($urandom_range(1, 255)));
    end
    // request header
    bytes_q.push_back((bad && $urandom_range(0, 6) == 0) ? 8'($urandom) : SOCKS_VER);
    bytes_q.push_back((bad && $urandom_range(0, 6) == 0) ? 8'($urandom) : CMD_CONNECT);
    bytes_q.push_back(8'($urandom));
    bytes_q.push_back((bad && $urandom_range(0, 6) == 0) ? 8'($urandom) : ATYP_DOMAIN);
    if (bad && $urandom_range(0, 29) == 0) alen = $urandom_range(64, 255);
    else if (bad && $urandom_range(0, 2) == 0) alen = $urandom_range(0, 63);
    else alen = HASH_LEN;
    bytes_q.push_back(8'(alen));
    // domain and port
    for (int i = 0; i < alen; i++) begin
      if (alen != HASH_LEN || (bad && $urandom_range(0, 39) == 0))
        bytes_q.push_back(8'($urandom));
      else
        bytes_q.push_back(rand_hex_char());
    end
    bytes_q.push_back(8'($urandom));
    bytes_q.push_back(8'($urandom));
    // stray bytes after the end, or a session cut short
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) bytes_q.push_back(8'($urandom));
    cut = bytes_q.size();
    if (bad && $urandom_range(0, 6) == 0) cut = $urandom_range(1, bytes_q.size());
    send_beat(BEAT_NEW, 8'($urandom));
    for (int i = 0; i < cut; i++) send_beat(BEAT_BYTE, bytes_q[i]);
  endtask

  // bad version, zero methods, bytes after close
  task automatic test_greeting_errors();
    send_beat(BEAT_NEW, 8'hFF);
    send_beat(BEAT_BYTE, 8'h04);
    send_beat(BEAT_BYTE, SOCKS_VER);
    send_beat(BEAT_BYTE, SOCKS_VER);
    send_beat(BEAT_NEW, 8'h00);
    send_beat(BEAT_BYTE, SOCKS_VER);
    send_beat(BEAT_BYTE, 8'h00);
  endtask

  // reserved byte ignored, empty domain, unsupported command
  task automatic test_request_errors();
    send_beat(BEAT_NEW, 8'h5A);
    send_beat(BEAT_BYTE, SOCKS_VER);
    send_beat(BEAT_BYTE, 8'h01);
    send_beat(BEAT_BYTE, METHOD_NOAUTH);
    send_beat(BEAT_BYTE, SOCKS_VER);
    send_beat(BEAT_BYTE, CMD_CONNECT);
    send_beat(BEAT_BYTE, 8'hFF);
    send_beat(BEAT_BYTE, ATYP_DOMAIN);
    send_beat(BEAT_BYTE, 8'h00);
    send_beat(BEAT_BYTE, 8'h00);
    send_beat(BEAT_BYTE, 8'hFF);
    send_beat(BEAT_NEW, 8'hA5);
    send_beat(BEAT_BYTE, SOCKS_VER);
    send_beat(BEAT_BYTE, 8'h01);
    send_beat(BEAT_BYTE, METHOD_NOAUTH);
    send_beat(BEAT_BYTE, SOCKS_VER);
    send_beat(BEAT_BYTE, 8'h02);
    send_beat(BEAT_BYTE, 8'h00);
    send_beat(BEAT_BYTE, ATYP_DOMAIN);
    send_beat(BEAT_BYTE, 8'h28);
  endtask

  // output held for a long stretch while a whole session is offered
  task automatic test_output_hold();
    idle_on      = 1'b0;
    hold_pending = 1'b1;
    send_session(1'b1);
    idle_on = 1'b1;
  endtask

  // mostly well-formed sessions, some broken ones, some byte noise;
  // stops a little short of the total so the last session lands near it
  task automatic test_random_sessions();
    int r;
    while (beats_sent < TOTAL_BEATS - 20) begin
      idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_session(1'b1);
      end else if (r < 90) begin
        send_session(1'b0);
      end else begin
        send_beat(BEAT_NEW, 8'($urandom));
        repeat ($urandom_range(1, 12)) send_beat(BEAT_BYTE, 8'($urandom));
      end
    end
    idle_on = 1'b1;
  endtask

  // output side: check each taken result, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_beat = '{kind: out_kind_o, data: out_byte_o, verdict: verdict_o, last: last_o};
      results_checked++;
      if (session_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: kind %0d byte %h verdict %0d last %0d",
                   got_beat.kind, got_beat.data, got_beat.verdict, got_beat.last);
      end else begin
        want_beat = session_out_q.pop_front();
        if (got_beat !== want_beat) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("result mismatch: expected kind %0d byte %h verdict %0d last %0d",
                     want_beat.kind, want_beat.data, want_beat.verdict, want_beat.last);
            $display("                 got      kind %0d byte %h verdict %0d last %0d",
                     got_beat.kind, got_beat.data, got_beat.verdict, got_beat.last);
          end
        end
      end
    end
    if (hold_pending) begin
      hold_left    = HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat taken on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no beat taken for %0d cycles", IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = BEAT_BYTE;
    data_byte_i  = 8'h00;
    idle_on      = 1'b1;
    hold_pending = 1'b0;
    hold_left    = 0;
    stall_left   = 0;
    clear_session();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_greeting_errors();
    test_request_errors();
    test_output_hold();
    test_random_sessions();
    in_valid_i <= 1'b0;

    // drain, then give stray results a chance to show
    idle_on = 1'b0;
    while (session_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("sent %0d input beats, %0d live, over %0d sessions: %0d accepted, %0d rejected",
             beats_sent, beats_counted, sessions_started, sessions_accepted,
             sessions_rejected);
    $display("checked %0d results with %0d mismatches, including a %0d-cycle output hold",
             results_checked, mismatches, HOLD_CYCLES);
    if (mismatches == 0 && session_out_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/s5hp_pkg.sv
sv/s5hp_parser.sv
sv/s5hp_emit.sv
sv/socks5_connect_handshake_parser_top.sv
bench/tb_socks5_connect_handshake_parser_top.sv
